// ===== src/spq_pkg.sv =====
// Package for the sorted-array priority queue: payload structs, codes,
// state encoding and default sizes. Used by every module in src.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int COST_WIDTH_DEF = 32;
   localparam int ID_W           = 16;
   localparam int COST_IN_W      = 32;
   localparam int STATUS_W       = 2;
   localparam int FILL_W         = 5;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE       = 2'd0,
      STAT_DROP_FULL  = 2'd1,
      STAT_EMPTY_POP  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_REPORT = 1'b1
   } st_type;

   typedef struct packed {
      logic                        cmd;
      logic [ID_W-1:0]             node_id;
      logic signed [COST_IN_W-1:0] cost;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     popped_id;
      logic [ID_W-1:0]     lowest_id;
      logic [ID_W-1:0]     highest_id;
      logic [FILL_W-1:0]   fill;
      logic                is_empty;
   } rsp_type;

endpackage : spq_pkg
`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted queue: holds an id and a cost, and on an insert
// either keeps them, takes the new entry or takes its left neighbor's entry.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
   parameter int COST_WIDTH = spq_pkg::COST_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          insert_en,
   input  wire logic [spq_pkg::ID_W-1:0] new_id,
   input  wire logic signed [COST_WIDTH-1:0] new_key,
   input  wire                          occupied,
   input  wire                          open_slot,
   input  wire                          left_gt,
   input  wire logic [spq_pkg::ID_W-1:0] left_id,
   input  wire logic signed [COST_WIDTH-1:0] left_cost,
   output logic                         gt,
   output logic [spq_pkg::ID_W-1:0]      id_out,
   output logic signed [COST_WIDTH-1:0]  cost_out
);
   import spq_pkg::*;

   logic [ID_W-1:0]              id_ff, id_in;
   logic signed [COST_WIDTH-1:0] cost_ff, cost_in;

   // This slot moves when the new key beats it, or when it is the first free slot.
   assign gt = open_slot | (occupied & (new_key > cost_ff));

   always_comb begin
      id_in   = id_ff;
      cost_in = cost_ff;
      if (insert_en && gt) begin
         if (left_gt) begin
            id_in   = left_id;
            cost_in = left_cost;
         end else begin
            id_in   = new_id;
            cost_in = new_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      cost_ff <= cost_in;
   end

   assign id_out   = id_ff;
   assign cost_out = cost_ff;

endmodule : spq_cell
`default_nettype wire

// ===== src/sorted_array_priority_queue_core.sv =====
// Top level of the sorted-array priority queue: a row of spq_cell slots,
// the fill counter, the control sequencer and the result register.
// Depends on spq_pkg and spq_cell.
//
// Each item passes through an accept cycle, where the cells compare the new cost
// in parallel and shift one slot toward the tail, and then the report state, where
// head, tail and count are read back into the result register. A new item is taken
// in the cycle after the report is loaded, so the next item can be accepted while
// the previous result still waits on rsp_ready; the report of the following item
// then waits until the result register frees up. Entries of equal cost leave in
// reverse order of insertion.
`timescale 1ns / 1ps
`default_nettype none
module sorted_array_priority_queue_core #(
   parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
   parameter int COST_WIDTH = spq_pkg::COST_WIDTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire spq_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output spq_pkg::rsp_type     rsp_data
);
   import spq_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W   = $clog2(CAPACITY);

   st_type state_ff, state_in;
   logic   req_take, rsp_load;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   tail_idx;
   logic               is_full, is_zero, do_insert, do_remove;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     popped_ff, popped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic signed [COST_WIDTH-1:0] new_key;
   logic [ID_W-1:0]              cell_id   [CAPACITY];
   logic signed [COST_WIDTH-1:0] cell_cost [CAPACITY];
   logic                         cell_gt   [CAPACITY];

   assign new_key   = COST_WIDTH'(req_data.cost);
   assign is_full   = (count_ff == COUNT_W'(CAPACITY));
   assign is_zero   = (count_ff == '0);
   assign tail_idx  = IDX_W'(count_ff - 1'b1);
   assign do_insert = req_take && (req_data.cmd == CMD_INSERT) && !is_full;
   assign do_remove = req_take && (req_data.cmd == CMD_REMOVE) && !is_zero;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                         l_gt;
      logic [ID_W-1:0]              l_id;
      logic signed [COST_WIDTH-1:0] l_cost;
      if (i == 0) begin : g_head
         assign l_gt   = 1'b0;
         assign l_id   = '0;
         assign l_cost = '0;
      end else begin : g_body
         assign l_gt   = cell_gt[i-1];
         assign l_id   = cell_id[i-1];
         assign l_cost = cell_cost[i-1];
      end
      spq_cell #(
         .COST_WIDTH(COST_WIDTH)
      ) u_cell (
         .clock     (clock),
         .insert_en (do_insert),
         .new_id    (req_data.node_id),
         .new_key   (new_key),
         .occupied  (COUNT_W'(i) < count_ff),
         .open_slot (COUNT_W'(i) == count_ff),
         .left_gt   (l_gt),
         .left_id   (l_id),
         .left_cost (l_cost),
         .gt        (cell_gt[i]),
         .id_out    (cell_id[i]),
         .cost_out  (cell_cost[i])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_REPORT;
         ST_REPORT: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_REPORT: rsp_load  = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign req_take = req_valid && req_ready;

   always_comb begin
      count_in = count_ff;
      if (do_insert) count_in = count_ff + 1'b1;
      else if (do_remove) count_in = count_ff - 1'b1;
   end

   // Capture status and popped id from the state before the update.
   always_comb begin
      status_in = status_ff;
      popped_in = popped_ff;
      if (req_take) begin
         popped_in = '0;
         if (req_data.cmd == CMD_INSERT) begin
            status_in = is_full ? STAT_DROP_FULL : STAT_DONE;
         end else begin
            status_in = is_zero ? STAT_EMPTY_POP : STAT_DONE;
            if (!is_zero) popped_in = cell_id[tail_idx];
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = status_ff;
         rsp_data_in.popped_id  = popped_ff;
         rsp_data_in.lowest_id  = is_zero ? '0 : cell_id[tail_idx];
         rsp_data_in.highest_id = is_zero ? '0 : cell_id[0];
         rsp_data_in.fill       = FILL_W'(count_ff);
         rsp_data_in.is_empty   = is_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : sorted_array_priority_queue_core
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for sorted_array_priority_queue_core: directed and random queue operations,
// with each report checked against a local sorted-array model of the queue.
// Depends on spq_pkg and the core RTL in src.
`timescale 1ns / 1ps
module tb;
   import spq_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model of the queue contents, head at slot 0
   logic [ID_W-1:0]             pq_ids [SLOTS];
   logic signed [COST_IN_W-1:0] pq_costs [SLOTS];
   int                          pq_count = 0;

   rsp_type report_fifo[$];
   int      fail_count = 0;
   int      report_count = 0;
   bit      src_idle_on = 1'b0;
   bit      sink_idle_on = 1'b0;
   int      sink_stall = 0;

   sorted_array_priority_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type pq_apply(req_type op);
      rsp_type                     r;
      logic signed [COST_IN_W-1:0] key;
      int                          pos;
      r = '0;
      r.status = STAT_DONE;
      key = op.cost;
      if (op.cmd == CMD_INSERT) begin
         if (pq_count >= SLOTS) begin
            r.status = STAT_DROP_FULL;
         end else begin
            // shift every strictly lower-cost entry one slot toward the tail
            pos = pq_count;
            while (pos > 0 && key > pq_costs[pos-1]) begin
               pq_ids[pos] = pq_ids[pos-1];
               pq_costs[pos] = pq_costs[pos-1];
               pos--;
            end
            pq_ids[pos] = op.node_id;
            pq_costs[pos] = key;
            pq_count++;
         end
      end else begin
         if (pq_count == 0) begin
            r.status = STAT_EMPTY_POP;
         end else begin
            pq_count--;
            r.popped_id = pq_ids[pq_count];
         end
      end
      if (pq_count > 0) begin
         r.lowest_id = pq_ids[pq_count-1];
         r.highest_id = pq_ids[0];
      end
      r.fill = FILL_W'(pq_count);
      r.is_empty = (pq_count == 0);
      return r;
   endfunction

   function automatic logic signed [COST_IN_W-1:0] pick_cost();
      case ($urandom_range(0, 3))
         0: pick_cost = $urandom;
         1: pick_cost = $signed($urandom_range(0, 6)) - 3;
         2: pick_cost = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: pick_cost = $urandom_range(0, 40);
      endcase
   endfunction

   task automatic push_op(cmd_type op_cmd, logic [ID_W-1:0] op_id,
                          logic signed [COST_IN_W-1:0] op_cost);
      req_type op;
      int      gap;
      op.cmd = op_cmd;
      op.node_id = op_id;
      op.cost = op_cost;
      if (src_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= op;
      do @(posedge clock); while (req_ready !== 1'b1);
      report_fifo.push_back(pq_apply(op));
   endtask

   task automatic random_op(int insert_pct);
      if ($urandom_range(1, 100) <= insert_pct) begin
         push_op(CMD_INSERT, ID_W'($urandom), pick_cost());
      end else begin
         // payload is ignored on remove; send noise anyway
         push_op(CMD_REMOVE, ID_W'($urandom), $urandom);
      end
   endtask

   task automatic hold_until_reported();
      req_valid <= 1'b0;
      while (report_fifo.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_queue();
      push_op(CMD_REMOVE, 16'h1234, 32'sh0000_0001);
      push_op(CMD_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
      push_op(CMD_INSERT, 16'h0000, 32'sh8000_0000);
      push_op(CMD_REMOVE, 16'h0000, 32'sh0);
      push_op(CMD_REMOVE, 16'hFFFF, 32'shFFFF_FFFF);
      push_op(CMD_REMOVE, 16'h0000, 32'sh0);
   endtask

   task automatic test_fill_to_capacity();
      logic signed [COST_IN_W-1:0] fill_costs [SLOTS];
      fill_costs = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 5, 5, 5, 1,
                     -5, 100, 5, -1, 32'sh8000_0000, 32'sh7FFF_FFFF, 7, 0};
      for (int i = 0; i < SLOTS; i++)
         push_op(CMD_INSERT, 16'hA5A0 + 16'(i), fill_costs[i]);
      // one more: dropped, queue stays full
      push_op(CMD_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
   endtask

   task automatic test_random_traffic(int blocks);
      int bias;
      for (int b = 0; b < blocks; b++) begin
         case ($urandom_range(0, 2))
            0: bias = 20;
            1: bias = 50;
            default: bias = 80;
         endcase
         src_idle_on = ($urandom_range(0, 2) != 0);
         sink_idle_on = ($urandom_range(0, 2) != 0);
         for (int i = 0; i < 100; i++) random_op(bias);
      end
   endtask

   task automatic test_pause_until_drained();
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      for (int round = 0; round < 5; round++) begin
         for (int i = 0; i < 8; i++) random_op(60);
         hold_until_reported();
      end
   endtask

   task automatic test_steady_traffic(int count);
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      for (int i = 0; i < count; i++) random_op((i / 50) % 2 == 0 ? 70 : 30);
   endtask

   // result side: stall in random bursts while enabled
   always @(posedge clock) begin
      if (sink_stall != 0) begin
         sink_stall <= sink_stall - 1;
         rsp_ready <= (sink_stall == 1);
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
         sink_stall <= $urandom_range(1, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         report_count++;
         if (report_fifo.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("tb: report %0d arrived with no item pending", report_count);
         end else begin
            want = report_fifo.pop_front();
            if (rsp_data.status !== want.status || rsp_data.popped_id !== want.popped_id ||
                rsp_data.lowest_id !== want.lowest_id ||
                rsp_data.highest_id !== want.highest_id ||
                rsp_data.fill !== want.fill || rsp_data.is_empty !== want.is_empty) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("tb: report %0d mismatch", report_count);
                  $display("tb:   got  st=%0d pop=%h low=%h high=%h fill=%0d empty=%b",
                           rsp_data.status, rsp_data.popped_id, rsp_data.lowest_id,
                           rsp_data.highest_id, rsp_data.fill, rsp_data.is_empty);
                  $display("tb:   want st=%0d pop=%h low=%h high=%h fill=%0d empty=%b",
                           want.status, want.popped_id, want.lowest_id,
                           want.highest_id, want.fill, want.is_empty);
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      test_empty_queue();
      test_fill_to_capacity();
      test_random_traffic(13);
      test_pause_until_drained();
      test_steady_traffic(300);
      hold_until_reported();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && report_fifo.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: timeout, %0d reports still pending", report_fifo.size());
      $display("tb: FAIL");
      $finish;
   end

endmodule
